>>> rtl/ssge_pkg.sv
// Shared types and constants for the slow-start goodput estimator.
package ssge_pkg;

	localparam int unsigned US_PER_SEC = 1000000;
	localparam int US_W = 20;
	localparam int MSSE6_W = 36;
	localparam int ALU_W = 128;
	localparam int DVS_W = 64;
	localparam int ITER_W = 7;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_RTT_ZERO = 3'd1,
		ST_SLOW     = 3'd2,
		ST_FAST     = 3'd3,
		ST_BAD      = 3'd4
	} status_t;

	typedef enum logic {
		OP_MUL,
		OP_DIV
	} alu_op_t;

	typedef struct packed {
		logic              start;
		alu_op_t           op;
		logic [ITER_W-1:0] iters;
	} alu_ctl_t;

	typedef struct packed {
		logic [39:0] total_bytes;
		logic [9:0]  init_window_pkts;
		logic [15:0] segment_bytes;
		logic [31:0] min_rtt_us;
		logic [39:0] elapsed_us;
	} rec_t;

	typedef struct packed {
		logic [31:0] goodput_bps;
		logic [5:0]  rounds_in_slow_start;
		logic [47:0] projected_window_pkts;
		logic [49:0] last_window_pkts;
		logic [2:0]  status;
	} est_t;

	typedef enum logic [4:0] {
		S_IDLE,
		S_XFER,
		S_MSSE6,
		S_WM0,
		S_CHK,
		S_TP_MUL,
		S_TP_DIV,
		S_SS_MUL,
		S_SS_DIV,
		S_XM_MUL,
		S_XM_DIV,
		S_MDL_MUL,
		S_CMP,
		S_BACK,
		S_BASE,
		S_RB_MUL,
		S_ACH_MUL,
		S_ACH_DIV,
		S_PQ_MUL,
		S_PQ_DIV,
		S_EMIT
	} state_t;

endpackage

>>> rtl/ssge_chan_if.sv
// Valid/ready channel carrying one request or result.
interface ssge_chan_if #(parameter type T = logic) ();
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

>>> rtl/ssge_alu.sv
// Bit-serial shift-add multiplier and restoring divider, one bit per cycle.
module ssge_alu (
	input  logic                     clk,
	input  logic                     arst_n,
	input  ssge_pkg::alu_ctl_t       ctl,
	input  logic [ssge_pkg::ALU_W-1:0] opa,
	input  logic [ssge_pkg::DVS_W-1:0] opb,
	output logic                     done,
	output logic [ssge_pkg::ALU_W-1:0] res
);
	import ssge_pkg::*;

	logic              busy_q;
	logic              done_q;
	alu_op_t           op_q;
	logic [ITER_W-1:0] cnt_q;
	logic [ALU_W-1:0]  acc_q;
	logic [ALU_W-1:0]  mcand_q;
	logic [DVS_W-1:0]  b_q;
	logic [DVS_W-1:0]  r_q;
	logic [DVS_W:0]    rs;
	logic [DVS_W:0]    rdiff;
	logic              ge;

	assign rs    = {r_q, acc_q[ALU_W-1]};
	assign rdiff = rs - {1'b0, b_q};
	assign ge    = (rs >= {1'b0, b_q});
	assign done  = done_q;
	assign res   = acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			op_q   <= OP_MUL;
		end else begin
			done_q <= busy_q && (cnt_q == ITER_W'(1));
			if (ctl.start) begin
				busy_q <= 1'b1;
				cnt_q  <= ctl.iters;
				op_q   <= ctl.op;
			end else if (busy_q) begin
				cnt_q <= cnt_q - ITER_W'(1);
				if (cnt_q == ITER_W'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			acc_q   <= (ctl.op == OP_DIV) ? opa : '0;
			mcand_q <= opa;
			b_q     <= opb;
			r_q     <= '0;
		end else if (busy_q) begin
			if (op_q == OP_MUL) begin
				acc_q <= {acc_q[ALU_W-2:0], 1'b0} + (b_q[DVS_W-1] ? mcand_q : '0);
				b_q   <= {b_q[DVS_W-2:0], 1'b0};
			end else begin
				acc_q <= {acc_q[ALU_W-2:0], ge};
				r_q   <= ge ? rdiff[DVS_W-1:0] : rs[DVS_W-1:0];
			end
		end
	end

`ifndef SYNTHESIS
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.start |-> !busy_q)
		else $error("alu started while busy");
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(busy_q) && !busy_q)
		else $error("alu done without a finished run");
	a_rem_below_div: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && op_q == OP_DIV && b_q != '0 |-> r_q < b_q)
		else $error("remainder not below divisor");
`endif

endmodule

>>> rtl/slow_start_goodput_estimator_top.sv
// Slow-start goodput estimator: sequencer around one shared bit-serial multiply/divide unit.
// Zero RTT or bad input goes from idle straight to the emit state and reports only a status.
// Throughput: one request at a time; the next is taken once the previous result is registered.
// Reset: arst_n clears the sequencer, the unit control and the output valid asynchronously.
module slow_start_goodput_estimator_top #(
	parameter int ROUND_LIMIT = 48
) (
	input logic          clk,
	input logic          arst_n,
	ssge_chan_if.sink    rec,
	ssge_chan_if.source  est
);
	import ssge_pkg::*;

	localparam int RW     = $clog2(ROUND_LIMIT + 2);
	localparam int W_XFER = 41;
	localparam int W_MSS  = 16;
	localparam int W_RTT  = 32;
	localparam int W_T    = 84;
	localparam int W_SS   = MSSE6_W + RW;
	localparam int W_XM   = 60;
	localparam int W_PQ   = 116;
	localparam logic [DVS_W-1:0] US_AL = DVS_W'(US_PER_SEC) << (DVS_W - US_W);

	state_t           state_q, state_d;
	logic             run_q;
	logic             ovalid_q;
	est_t             est_q;
	alu_ctl_t         ctl;
	logic [ALU_W-1:0] opa;
	logic [DVS_W-1:0] opb;
	logic             alu_done;
	logic [ALU_W-1:0] alu_res;

	logic [39:0]        bytes_q;
	logic [9:0]         iw_q;
	logic [15:0]        mss_q;
	logic [31:0]        rtt_q;
	logic [39:0]        el_q;
	status_t            status_q;
	logic [W_XFER-1:0]  xfer_q;
	logic [MSSE6_W-1:0] msse6_q;
	logic [63:0]        wm_q;
	logic [63:0]        cwnd_q;
	logic [63:0]        cum_q;
	logic [63:0]        cm_q;
	logic [RW-1:0]      rounds_q;
	logic [63:0]        tput_q;
	logic [63:0]        mdl_q;
	logic [ALU_W-1:0]   tmp_q;
	logic [39:0]        remt_q;
	logic [W_T-1:0]     ach_q;
	logic [47:0]        proj_q;

	logic [63:0] tput_w;
	logic        bad_rtt;
	logic        bad_in;
	logic        loop_go;
	logic        model_met;
	logic        too_fast;
	logic        emit_go;

	assign tput_w    = (|alu_res[W_T-1:64]) ? '1 : alu_res[63:0];
	assign bad_rtt   = (rec.data.min_rtt_us == '0);
	assign bad_in    = (rec.data.segment_bytes == '0) || (rec.data.total_bytes == '0);
	assign loop_go   = (cum_q < 64'(xfer_q)) && (rounds_q < RW'(ROUND_LIMIT));
	assign model_met = (64'(el_q) >= mdl_q);
	assign too_fast  = (64'(el_q) <= alu_res[63:0]);
	assign emit_go   = !ovalid_q || est.ready;

	ssge_alu u_alu (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.opa    (opa),
		.opb    (opb),
		.done   (alu_done),
		.res    (alu_res)
	);

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (rec.valid) begin
					state_d = (bad_rtt || bad_in) ? S_EMIT : S_XFER;
				end
			end
			S_XFER:    if (alu_done) state_d = S_MSSE6;
			S_MSSE6:   if (alu_done) state_d = S_WM0;
			S_WM0:     if (alu_done) state_d = S_CHK;
			S_CHK:     state_d = loop_go ? S_TP_MUL : S_BACK;
			S_TP_MUL:  if (alu_done) state_d = S_TP_DIV;
			S_TP_DIV: begin
				if (alu_done) begin
					state_d = (tput_w == '0) ? S_EMIT : S_SS_MUL;
				end
			end
			S_SS_MUL:  if (alu_done) state_d = S_SS_DIV;
			S_SS_DIV:  if (alu_done) state_d = S_XM_MUL;
			S_XM_MUL:  if (alu_done) state_d = S_XM_DIV;
			S_XM_DIV:  if (alu_done) state_d = S_MDL_MUL;
			S_MDL_MUL: if (alu_done) state_d = S_CMP;
			S_CMP:     state_d = model_met ? S_BACK : S_CHK;
			S_BACK:    state_d = S_BASE;
			S_BASE: begin
				if (alu_done) begin
					state_d = too_fast ? S_EMIT : S_RB_MUL;
				end
			end
			S_RB_MUL:  if (alu_done) state_d = S_ACH_MUL;
			S_ACH_MUL: if (alu_done) state_d = S_ACH_DIV;
			S_ACH_DIV: if (alu_done) state_d = S_PQ_MUL;
			S_PQ_MUL:  if (alu_done) state_d = S_PQ_DIV;
			S_PQ_DIV:  if (alu_done) state_d = S_EMIT;
			S_EMIT:    if (emit_go) state_d = S_IDLE;
			default:   state_d = S_IDLE;
		endcase
	end

	always_comb begin
		rec.ready = (state_q == S_IDLE);
		ctl.start = 1'b0;
		ctl.op    = OP_MUL;
		ctl.iters = ITER_W'(1);
		opa       = '0;
		opb       = '0;
		case (state_q)
			S_XFER: begin
				ctl.start = !run_q;
				ctl.op    = OP_DIV;
				ctl.iters = ITER_W'(W_XFER);
				opa       = (ALU_W'(bytes_q) + ALU_W'(mss_q) - ALU_W'(1)) << (ALU_W - W_XFER);
				opb       = DVS_W'(mss_q);
			end
			S_MSSE6: begin
				ctl.start = !run_q;
				ctl.iters = ITER_W'(US_W);
				opa       = ALU_W'(mss_q);
				opb       = US_AL;
			end
			S_WM0: begin
				ctl.start = !run_q;
				ctl.iters = ITER_W'(W_MSS);
				opa       = ALU_W'(iw_q);
				opb       = {mss_q, {(DVS_W - W_MSS){1'b0}}};
			end
			S_TP_MUL: begin
				ctl.start = !run_q;
				ctl.iters = ITER_W'(US_W);
				opa       = ALU_W'(wm_q);
				opb       = US_AL;
			end
			S_TP_DIV: begin
				ctl.start = !run_q;
				ctl.op    = OP_DIV;
				ctl.iters = ITER_W'(W_T);
				opa       = tmp_q << (ALU_W - W_T);
				opb       = DVS_W'(rtt_q);
			end
			S_SS_MUL: begin
				ctl.start = !run_q;
				ctl.iters = ITER_W'(RW);
				opa       = ALU_W'(msse6_q);
				opb       = DVS_W'(rounds_q) << (DVS_W - RW);
			end
			S_SS_DIV: begin
				ctl.start = !run_q;
				ctl.op    = OP_DIV;
				ctl.iters = ITER_W'(W_SS);
				opa       = tmp_q << (ALU_W - W_SS);
				opb       = tput_q;
			end
			S_XM_MUL: begin
				ctl.start = !run_q;
				ctl.iters = ITER_W'(US_W);
				opa       = ALU_W'(64'(bytes_q) - cm_q);
				opb       = US_AL;
			end
			S_XM_DIV: begin
				ctl.start = !run_q;
				ctl.op    = OP_DIV;
				ctl.iters = ITER_W'(W_XM);
				opa       = tmp_q << (ALU_W - W_XM);
				opb       = tput_q;
			end
			S_MDL_MUL, S_BASE: begin
				ctl.start = !run_q;
				ctl.iters = ITER_W'(RW);
				opa       = ALU_W'(rtt_q);
				opb       = DVS_W'(rounds_q + RW'(1)) << (DVS_W - RW);
			end
			S_RB_MUL: begin
				ctl.start = !run_q;
				ctl.iters = ITER_W'(W_MSS);
				opa       = ALU_W'(64'(xfer_q) - cum_q + 64'(rounds_q));
				opb       = {mss_q, {(DVS_W - W_MSS){1'b0}}};
			end
			S_ACH_MUL: begin
				ctl.start = !run_q;
				ctl.iters = ITER_W'(US_W);
				opa       = ALU_W'(tmp_q[63:0]);
				opb       = US_AL;
			end
			S_ACH_DIV: begin
				ctl.start = !run_q;
				ctl.op    = OP_DIV;
				ctl.iters = ITER_W'(W_T);
				opa       = tmp_q << (ALU_W - W_T);
				opb       = DVS_W'(remt_q);
			end
			S_PQ_MUL: begin
				ctl.start = !run_q;
				ctl.iters = ITER_W'(W_RTT);
				opa       = ALU_W'(ach_q);
				opb       = {rtt_q, {(DVS_W - W_RTT){1'b0}}};
			end
			S_PQ_DIV: begin
				ctl.start = !run_q;
				ctl.op    = OP_DIV;
				ctl.iters = ITER_W'(W_PQ);
				opa       = tmp_q << (ALU_W - W_PQ);
				opb       = DVS_W'(msse6_q);
			end
			default: begin
				ctl.start = 1'b0;
			end
		endcase
	end

	assign est.valid = ovalid_q;
	assign est.data  = est_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			run_q    <= 1'b0;
			ovalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ctl.start) begin
				run_q <= 1'b1;
			end else if (alu_done) begin
				run_q <= 1'b0;
			end
			if (state_q == S_EMIT && emit_go) begin
				ovalid_q <= 1'b1;
			end else if (est.ready) begin
				ovalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (rec.valid) begin
					bytes_q  <= rec.data.total_bytes;
					iw_q     <= rec.data.init_window_pkts;
					mss_q    <= rec.data.segment_bytes;
					rtt_q    <= rec.data.min_rtt_us;
					el_q     <= rec.data.elapsed_us;
					status_q <= bad_rtt ? ST_RTT_ZERO : (bad_in ? ST_BAD : ST_OK);
				end
			end
			S_XFER:  if (alu_done) xfer_q <= alu_res[W_XFER-1:0];
			S_MSSE6: if (alu_done) msse6_q <= alu_res[MSSE6_W-1:0];
			S_WM0: begin
				if (alu_done) begin
					wm_q     <= alu_res[63:0];
					cwnd_q   <= 64'(iw_q);
					cum_q    <= '0;
					cm_q     <= '0;
					rounds_q <= '0;
				end
			end
			S_TP_MUL, S_SS_MUL, S_XM_MUL, S_RB_MUL, S_ACH_MUL, S_PQ_MUL: begin
				if (alu_done) tmp_q <= alu_res;
			end
			S_TP_DIV: begin
				if (alu_done) begin
					tput_q <= tput_w;
					if (tput_w == '0) status_q <= ST_SLOW;
				end
			end
			S_SS_DIV: if (alu_done) mdl_q <= alu_res[63:0];
			S_XM_DIV, S_MDL_MUL: begin
				if (alu_done) mdl_q <= mdl_q + alu_res[63:0];
			end
			S_CMP: begin
				if (!model_met) begin
					rounds_q <= rounds_q + RW'(1);
					cum_q    <= cum_q + cwnd_q;
					cwnd_q   <= {cwnd_q[62:0], 1'b0};
					cm_q     <= cm_q + wm_q;
					wm_q     <= {wm_q[62:0], 1'b0};
				end
			end
			S_BACK: begin
				if (cum_q >= 64'(xfer_q)) begin
					cwnd_q   <= {1'b0, cwnd_q[63:1]};
					cum_q    <= cum_q - {1'b0, cwnd_q[63:1]};
					rounds_q <= rounds_q - RW'(1);
				end
			end
			S_BASE: begin
				if (alu_done) begin
					remt_q <= 40'(64'(el_q) - alu_res[63:0]);
					if (too_fast) status_q <= ST_FAST;
				end
			end
			S_ACH_DIV: if (alu_done) ach_q <= alu_res[W_T-1:0];
			S_PQ_DIV: begin
				if (alu_done) begin
					proj_q <= (|alu_res[ALU_W-1:48]) ? '1 : alu_res[47:0];
				end
			end
			S_EMIT: begin
				if (emit_go) begin
					if (status_q == ST_OK) begin
						est_q.goodput_bps           <= ach_q[31:0];
						est_q.rounds_in_slow_start  <= 6'(rounds_q);
						est_q.projected_window_pkts <= proj_q;
						est_q.last_window_pkts      <= cwnd_q[49:0];
					end else begin
						est_q.goodput_bps           <= '0;
						est_q.rounds_in_slow_start  <= '0;
						est_q.projected_window_pkts <= '0;
						est_q.last_window_pkts      <= '0;
					end
					est_q.status <= status_q;
				end
			end
			default: begin
				tmp_q <= tmp_q;
			end
		endcase
	end

endmodule

>>> test/tb_slow_start_goodput_estimator_top.sv
// Self-checking testbench for the slow-start goodput estimator: directed records, random records, checked results.
`timescale 1ns / 100ps

module tb_slow_start_goodput_estimator_top;
	import ssge_pkg::*;

	localparam int ROUND_LIMIT = 48;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	bit   failed = 1'b0;
	bit   no_idle = 1'b0;
	est_t pending_estimates[$];

	ssge_chan_if #(.T(rec_t)) rec_ch ();
	ssge_chan_if #(.T(est_t)) est_ch ();

	slow_start_goodput_estimator_top #(.ROUND_LIMIT(ROUND_LIMIT)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.rec(rec_ch.sink),
		.est(est_ch.source)
	);

	always #4 clk = ~clk;

	function automatic est_t estimate_goodput(rec_t r);
		logic [63:0] bytes, iw, mss, rtt, elapsed;
		logic [63:0] xfer, cum, cwnd, rounds, tput, ss, xm, mdl, base, rem_t, rem_bytes, wnd_b;
		logic [127:0] t, ach, prod, pq;
		est_t e;
		bytes = r.total_bytes;
		iw = r.init_window_pkts;
		mss = r.segment_bytes;
		rtt = r.min_rtt_us;
		elapsed = r.elapsed_us;
		e = '0;
		if (rtt == 0) begin
			e.status = ST_RTT_ZERO;
			return e;
		end
		if (mss == 0 || bytes == 0) begin
			e.status = ST_BAD;
			return e;
		end
		xfer = (bytes + mss - 64'd1) / mss;
		cum = 0;
		cwnd = iw;
		rounds = 0;
		while (cum < xfer && rounds < ROUND_LIMIT) begin
			wnd_b = cwnd * mss;
			t = (128'(wnd_b) * 128'd1000000) / 128'(rtt);
			tput = (t[127:64] != 0) ? '1 : t[63:0];
			if (tput == 0) begin
				e.status = ST_SLOW;
				return e;
			end
			ss = rounds * mss * 64'd1000000 / tput;
			xm = (bytes - cum * mss) * 64'd1000000 / tput;
			mdl = rtt * (rounds + 64'd1) + xm + ss;
			if (elapsed >= mdl)
				break;
			rounds = rounds + 1;
			cum = cum + cwnd;
			cwnd = cwnd << 1;
		end
		if (cum >= xfer) begin
			cwnd = cwnd >> 1;
			cum = cum - cwnd;
			rounds = rounds - 1;
		end
		base = rtt * (rounds + 64'd1);
		if (elapsed <= base) begin
			e.status = ST_FAST;
			return e;
		end
		rem_t = elapsed - base;
		rem_bytes = (xfer - cum + rounds) * mss;
		ach = (128'(rem_bytes) * 128'd1000000) / 128'(rem_t);
		prod = ach * 128'(rtt);
		pq = prod / (128'd1000000 * 128'(mss));
		e.goodput_bps = ach[31:0];
		e.rounds_in_slow_start = rounds[5:0];
		e.projected_window_pkts = (pq > 128'hFFFF_FFFF_FFFF) ? '1 : pq[47:0];
		e.last_window_pkts = cwnd[49:0];
		e.status = ST_OK;
		return e;
	endfunction

	function automatic logic [63:0] rand_bits(int max_w);
		int w;
		w = $urandom_range(1, max_w);
		return {$urandom, $urandom} & ((64'd1 << w) - 64'd1);
	endfunction

	task automatic send_record(rec_t r);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 14);
		if (gap > 0) begin
			rec_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		rec_ch.valid <= 1'b1;
		rec_ch.data <= r;
		do @(posedge clk); while (!rec_ch.ready);
		pending_estimates.push_back(estimate_goodput(r));
	endtask

	task automatic drain();
		rec_ch.valid <= 1'b0;
		while (pending_estimates.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
	endtask

	function automatic rec_t make_rec(logic [39:0] b, logic [9:0] iw, logic [15:0] m,
			logic [31:0] rtt, logic [39:0] el);
		rec_t r;
		r.total_bytes = b;
		r.init_window_pkts = iw;
		r.segment_bytes = m;
		r.min_rtt_us = rtt;
		r.elapsed_us = el;
		return r;
	endfunction

	task automatic test_error_cases();
		send_record(make_rec(40'd100000, 10'd10, 16'd1460, 32'd0, 40'd500000));
		send_record(make_rec(40'd100000, 10'd10, 16'd0, 32'd20000, 40'd500000));
		send_record(make_rec(40'd0, 10'd10, 16'd1460, 32'd20000, 40'd500000));
		send_record(make_rec(40'd100000, 10'd0, 16'd1460, 32'd20000, 40'd500000));
		send_record(make_rec(40'd100000, 10'd1, 16'd1, 32'hFFFF_FFFF, 40'd500000));
		send_record(make_rec(40'd100000, 10'd10, 16'd1460, 32'd20000, 40'd100));
		send_record(make_rec('1, '1, '1, '1, '1));
		send_record(make_rec('0, '0, '0, '0, '0));
	endtask

	task automatic test_slow_start_paths();
		send_record(make_rec(40'd5000, 10'd10, 16'd1460, 32'd20000, 40'd5000000));
		send_record(make_rec(40'd100000000, 10'd10, 16'd1460, 32'd20000, 40'd2000000));
		send_record(make_rec('1, 10'd1, 16'd1, 32'd1, '1));
		send_record(make_rec('1, 10'd1, 16'd1, 32'd1000, '1));
		send_record(make_rec(40'd1, 10'd1, 16'd1, 32'd1, 40'd3));
		send_record(make_rec('1, '1, '1, 32'd1, 40'd48));
		send_record(make_rec('1, 10'd1023, 16'd65535, 32'hFFFF_FFFF, '1));
		send_record(make_rec(40'd65535, 10'd1, 16'd65535, 32'd50, 40'd10000));
		send_record(make_rec(40'd3000000, 10'd4, 16'd536, 32'd80000, 40'd3000000));
	endtask

	task automatic test_random_records(int count);
		rec_t r;
		for (int i = 0; i < count; i++) begin
			if (i == count / 2)
				drain();
			no_idle = (i >= 20 && i < 30);
			if ($urandom_range(0, 4) == 0) begin
				r = make_rec(40'(rand_bits(40)), 10'(rand_bits(10)), 16'(rand_bits(16)),
					32'(rand_bits(32)), 40'(rand_bits(40)));
			end else begin
				r.segment_bytes = ($urandom_range(0, 2) == 0) ? 16'd1460 : 16'(rand_bits(16));
				r.init_window_pkts = ($urandom_range(0, 3) == 0) ? 10'(rand_bits(10))
					: 10'($urandom_range(1, 20));
				r.min_rtt_us = $urandom_range(100, 300000);
				r.total_bytes = 40'(rand_bits(34));
				r.elapsed_us = 40'(64'(r.min_rtt_us) * 64'($urandom_range(1, 40))
					+ rand_bits(30));
			end
			send_record(r);
		end
		no_idle = 1'b0;
	endtask

	initial begin
		int stall;
		est_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			stall = no_idle ? 0 : $urandom_range(0, 14);
			if (stall > 0) begin
				est_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			est_ch.ready <= 1'b1;
			do @(posedge clk); while (!est_ch.valid);
		end
	end

	always @(posedge clk) begin
		est_t want;
		if (est_ch.valid && est_ch.ready) begin
			if (pending_estimates.size() == 0) begin
				$display("%0t: unexpected result %p", $realtime, est_ch.data);
				failed = 1'b1;
			end else begin
				want = pending_estimates.pop_front();
				if (est_ch.data !== want) begin
					$display("%0t: mismatch expected %p actual %p", $realtime, want,
						est_ch.data);
					failed = 1'b1;
				end
			end
		end
	end

	initial begin
		rec_ch.valid <= 1'b0;
		rec_ch.data <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_error_cases();
		test_slow_start_paths();
		test_random_records(100);
		drain();
		if (!failed)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	initial begin
		#60000000;
		$display("simulation failed");
		$finish;
	end

endmodule

>>> files.f
rtl/ssge_pkg.sv
rtl/ssge_chan_if.sv
rtl/ssge_alu.sv
rtl/slow_start_goodput_estimator_top.sv
test/tb_slow_start_goodput_estimator_top.sv
